>>> hw/rtl/gclp_pkg.sv
`default_nettype none

package gclp_pkg;

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,  // awaiting the first data word of a command
		PH_HEADER = 4'b0010,  // awaiting the header word
		PH_DATA   = 4'b0100,  // extra data words
		PH_PAD    = 4'b1000   // padding word after an odd count
	} phase_t;

	// Header word layout.
	localparam int unsigned HDR_REG_LSB   = 0;
	localparam int unsigned HDR_REG_W     = 16;
	localparam int unsigned HDR_MASK_LSB  = 16;
	localparam int unsigned HDR_MASK_W    = 4;
	localparam int unsigned HDR_COUNT_LSB = 20;
	localparam int unsigned HDR_COUNT_W   = 11;
	localparam int unsigned HDR_GROUP_BIT = 31;

	localparam int unsigned WORD_W = 32;

	typedef struct packed {
		phase_t                   phase;
		logic [WORD_W-1:0]        held_word;
		logic [HDR_REG_W-1:0]     cur_reg;
		logic [HDR_MASK_W-1:0]    cur_mask;
		logic [HDR_COUNT_W-1:0]   words_left;
		logic                     group_mode;
		logic                     pad_pending;
	} state_t;

	typedef struct packed {
		logic [HDR_REG_W-1:0]     reg_id;
		logic [HDR_MASK_W-1:0]    byte_mask;
		logic [WORD_W-1:0]        write_data;
		logic                     last_write;
	} wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/gclp_step.sv
`default_nettype none

// Next-state and register-write decode for one command-list word.
module gclp_step (
	input  wire gclp_pkg::state_t             cur,
	input  wire logic [gclp_pkg::WORD_W-1:0] word,
	input  wire logic                        list_end,
	output gclp_pkg::state_t                  nxt,
	output logic                              emit,
	output gclp_pkg::wr_t                     wr
);

	logic [gclp_pkg::HDR_REG_W-1:0]   hdr_reg;
	logic [gclp_pkg::HDR_MASK_W-1:0]  hdr_mask;
	logic [gclp_pkg::HDR_COUNT_W-1:0] hdr_count;
	logic                             hdr_group;
	logic [gclp_pkg::HDR_COUNT_W-1:0] left_dec;

	assign hdr_reg   = word[gclp_pkg::HDR_REG_LSB +: gclp_pkg::HDR_REG_W];
	assign hdr_mask  = word[gclp_pkg::HDR_MASK_LSB +: gclp_pkg::HDR_MASK_W];
	assign hdr_count = word[gclp_pkg::HDR_COUNT_LSB +: gclp_pkg::HDR_COUNT_W];
	assign hdr_group = word[gclp_pkg::HDR_GROUP_BIT];

	assign left_dec = (cur.words_left != '0) ? cur.words_left - 1'b1 : cur.words_left;

	always_comb begin
		nxt           = cur;
		emit          = 1'b0;
		wr.reg_id     = cur.cur_reg;
		wr.byte_mask  = cur.cur_mask;
		wr.write_data = word;
		wr.last_write = 1'b0;

		case (cur.phase)
			gclp_pkg::PH_FIRST: begin
				nxt.held_word = word;
				nxt.phase     = gclp_pkg::PH_HEADER;
			end
			gclp_pkg::PH_HEADER: begin
				wr.reg_id        = hdr_reg;
				wr.byte_mask     = hdr_mask;
				wr.write_data    = cur.held_word;
				wr.last_write    = (hdr_count == '0);
				emit             = (hdr_mask != '0);
				nxt.cur_reg      = hdr_group ? hdr_reg + 1'b1 : hdr_reg;
				nxt.cur_mask     = hdr_mask;
				nxt.words_left   = hdr_count;
				nxt.group_mode   = hdr_group;
				nxt.pad_pending  = hdr_count[0];
				nxt.phase        = (hdr_count != '0) ? gclp_pkg::PH_DATA : gclp_pkg::PH_FIRST;
			end
			gclp_pkg::PH_DATA: begin
				emit           = (cur.cur_mask != '0);
				wr.last_write  = (cur.words_left == gclp_pkg::HDR_COUNT_W'(1));
				nxt.cur_reg    = cur.group_mode ? cur.cur_reg + 1'b1 : cur.cur_reg;
				nxt.words_left = left_dec;
				if (left_dec == '0) begin
					nxt.phase = cur.pad_pending ? gclp_pkg::PH_PAD : gclp_pkg::PH_FIRST;
				end
			end
			gclp_pkg::PH_PAD: begin
				nxt.pad_pending = 1'b0;
				nxt.phase       = gclp_pkg::PH_FIRST;
			end
			default: begin
				nxt.phase       = gclp_pkg::PH_FIRST;
				nxt.words_left  = '0;
				nxt.pad_pending = 1'b0;
			end
		endcase

		// End of list abandons whatever command is under way.
		if (list_end) begin
			nxt.phase       = gclp_pkg::PH_FIRST;
			nxt.words_left  = '0;
			nxt.pad_pending = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/gpu_command_list_parser_unit.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = command-list word, s_tlast = end of list
// m_*       out  m_tvalid/m_tready  m_tdata = register write, m_tlast = last write of command
//
// One word is taken per cycle; the decode of a word is combinational logic between
// the parser state registers and the output register, so a write appears on m_* in the
// cycle after the word that causes it. s_tready is high whenever the output register is
// empty or is being drained in the same cycle, so the parser stalls only while a
// finished write waits on m_tready. Reset (arst_n low) returns the parser to awaiting
// the first data word of a command and empties the output register.
module gpu_command_list_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [31:0] word
	input  wire logic [31:0] s_tdata,
	// list_end: high on the last word of the command list
	input  wire logic        s_tlast,

	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] reg_id, [19:16] byte_mask, [51:20] write_data, [55:52] zero
	output logic [55:0]      m_tdata,
	// last_write: high on the final write of a command
	output logic             m_tlast
);

	gclp_pkg::state_t st_q;
	gclp_pkg::state_t st_nxt;
	logic             emit;
	gclp_pkg::wr_t    wr;
	gclp_pkg::wr_t    out_q;
	logic             out_valid_q;
	logic             s_accept;

	// The word decoder: phase tracking, header unpacking and register id stepping.
	gclp_step u_step (
		.cur      (st_q),
		.word     (s_tdata),
		.list_end (s_tlast),
		.nxt      (st_nxt),
		.emit     (emit),
		.wr       (wr)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// Parser state advances only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= gclp_pkg::PH_FIRST;
			st_q.held_word   <= '0;
			st_q.cur_reg     <= '0;
			st_q.cur_mask    <= '0;
			st_q.words_left  <= '0;
			st_q.group_mode  <= 1'b0;
			st_q.pad_pending <= 1'b0;
		end else if (s_accept) begin
			st_q <= st_nxt;
		end
	end

	// Output register: reloaded on every accepted word, which is only possible when
	// it is empty or being taken, so no write is ever overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && emit) begin
			out_q <= wr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.write_data, out_q.byte_mask, out_q.reg_id};
	assign m_tlast  = out_q.last_write;

endmodule

`default_nettype wire

>>> hw/rtl/gclp_checker.sv
`default_nettype none

module gclp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	// A write never carries an empty byte mask.
	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:16] != 4'h0))
		else $error("write with zero byte mask");

	// Pad bits of the output word stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:52] == 4'h0))
		else $error("output pad bits not zero");

	// The input side is open whenever the output is not stalled.
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled without output back-pressure");

	// A stalled write stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// A list-end word leaves the parser awaiting a first data word, which never writes.
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) ##1 (s_tvalid && s_tready) |=> !m_tvalid)
		else $error("first data word produced a write");

endmodule

bind gpu_command_list_parser_unit gclp_checker u_gclp_checker (.*);

`default_nettype wire

>>> tb/tb_gpu_command_list_parser_unit.sv
`timescale 1ns / 100ps

// Checks the command list parser: words go in on s_*, register writes come out on m_*.
// A model of the parse state runs on every word taken at s_* and queues the writes it
// predicts; each write that leaves on m_* is compared with the oldest queued one.
module tb_gpu_command_list_parser_unit;

	localparam int STUCK_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_WORDS = 500;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	// Parse state of the model.
	gclp_pkg::phase_t                 parse_phase = gclp_pkg::PH_FIRST;
	logic [gclp_pkg::WORD_W-1:0]      held_word = '0;
	logic [gclp_pkg::HDR_REG_W-1:0]   cur_reg = '0;
	logic [gclp_pkg::HDR_MASK_W-1:0]  cur_mask = '0;
	logic [gclp_pkg::HDR_COUNT_W-1:0] words_left = '0;
	logic                             group_mode = 1'b0;
	logic                             pad_pending = 1'b0;

	gclp_pkg::wr_t pending_writes[$];

	int  errors = 0;
	int  words_taken = 0;
	int  useful_words = 0;
	int  writes_checked = 0;
	int  stuck_cycles = 0;
	int  burst_left = 0;
	int  holds_done = 0;
	bit  steady_send = 1'b0;
	bit  hold_req = 1'b0;

	gpu_command_list_parser_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] make_header(input logic [15:0] reg_id,
			input logic [3:0] mask, input logic [10:0] count, input logic group);
		return {group, count, mask, reg_id};
	endfunction

	// Advances the model by one word and queues the write it causes, if any.
	// ignored comes back set for words that leave no trace: padding and the
	// data words of a command with a zero byte mask.
	task automatic parse_word(input logic [31:0] w, input logic list_end, output bit ignored);
		gclp_pkg::wr_t wr;
		ignored = 1'b0;
		case (parse_phase)
			gclp_pkg::PH_FIRST: begin
				held_word = w;
				parse_phase = gclp_pkg::PH_HEADER;
			end
			gclp_pkg::PH_HEADER: begin
				cur_reg = w[gclp_pkg::HDR_REG_LSB +: gclp_pkg::HDR_REG_W];
				cur_mask = w[gclp_pkg::HDR_MASK_LSB +: gclp_pkg::HDR_MASK_W];
				words_left = w[gclp_pkg::HDR_COUNT_LSB +: gclp_pkg::HDR_COUNT_W];
				group_mode = w[gclp_pkg::HDR_GROUP_BIT];
				pad_pending = words_left[0];
				if (cur_mask != '0) begin
					wr.reg_id = cur_reg;
					wr.byte_mask = cur_mask;
					wr.write_data = held_word;
					wr.last_write = (words_left == '0);
					pending_writes.push_back(wr);
				end
				if (group_mode)
					cur_reg = cur_reg + 1'b1;
				if (words_left != '0)
					parse_phase = gclp_pkg::PH_DATA;
				else
					parse_phase = gclp_pkg::PH_FIRST;
			end
			gclp_pkg::PH_DATA: begin
				if (cur_mask != '0) begin
					wr.reg_id = cur_reg;
					wr.byte_mask = cur_mask;
					wr.write_data = w;
					wr.last_write = (words_left == 11'd1);
					pending_writes.push_back(wr);
				end else begin
					ignored = 1'b1;
				end
				if (group_mode)
					cur_reg = cur_reg + 1'b1;
				if (words_left != '0)
					words_left = words_left - 1'b1;
				if (words_left == '0) begin
					if (pad_pending)
						parse_phase = gclp_pkg::PH_PAD;
					else
						parse_phase = gclp_pkg::PH_FIRST;
				end
			end
			default: begin
				pad_pending = 1'b0;
				parse_phase = gclp_pkg::PH_FIRST;
				ignored = 1'b1;
			end
		endcase
		// The end of the list abandons whatever command was in progress.
		if (list_end) begin
			parse_phase = gclp_pkg::PH_FIRST;
			words_left = '0;
			pad_pending = 1'b0;
		end
	endtask

	// Offers one word and returns once it has been taken. Outside steady mode the
	// sender works in bursts of random length, with random gaps between them.
	task automatic send_word(input logic [31:0] w, input logic list_end);
		int gap;
		bit ignored;
		if (!steady_send && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tlast <= list_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_word(w, list_end, ignored);
		words_taken++;
		if (!ignored)
			useful_words++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Sends a whole command: first data word, header, extra data words and, after an
	// odd count, the padding word. If cut names a word of the command, that word carries
	// the end of the list and the rest of the command is not sent.
	task automatic send_command(input logic [31:0] first, input logic [31:0] hdr, input int cut);
		int count;
		int total;
		logic [31:0] w;
		count = int'(hdr[gclp_pkg::HDR_COUNT_LSB +: gclp_pkg::HDR_COUNT_W]);
		total = 2 + count + (count % 2);
		for (int i = 0; i < total; i++) begin
			if (i == 0)
				w = first;
			else if (i == 1)
				w = hdr;
			else
				w = $urandom;
			send_word(w, i == cut);
			if (i == cut)
				break;
		end
	endtask

	// Stops offering words and waits until every predicted write has come out.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic test_single_writes();
		// Highest register id, all bytes, data all zeros; then all ones into id zero.
		send_command(32'h0000_0000, make_header(16'hFFFF, 4'hF, 11'd0, 1'b0), -1);
		send_command(32'hFFFF_FFFF, make_header(16'h0000, 4'h1, 11'd0, 1'b1), -1);
		wait_idle();
	endtask

	task automatic test_zero_mask();
		// Header, extra word and padding all vanish without a write.
		send_command($urandom, make_header(16'h1234, 4'h0, 11'd1, 1'b1), -1);
		wait_idle();
	endtask

	task automatic test_group_wrap();
		// Grouped ids step through 0xFFFF back to zero; the padding word is dropped.
		send_command($urandom, make_header(16'hFFFE, 4'hA, 11'd3, 1'b1), -1);
		// Without grouping every word lands on the same id.
		send_command($urandom, make_header(16'h0042, 4'h3, 11'd2, 1'b0), -1);
		wait_idle();
	endtask

	task automatic test_list_end_cut();
		// A first word that ends the list is dropped: its header never comes.
		send_word(32'hA5A5_5A5A, 1'b1);
		// End of list on the header: its one write goes out, not marked last.
		send_command($urandom, make_header(16'h0100, 4'h6, 11'd4, 1'b1), 1);
		// End of list on a data word in the middle of the command.
		send_command($urandom, make_header(16'h0200, 4'h9, 11'd5, 1'b0), 3);
		wait_idle();
	endtask

	task automatic test_max_count();
		// Largest extra-word count, cut off by the end of the list after a few dozen words.
		send_command($urandom,
			make_header(16'($urandom), 4'($urandom_range(1, 15)), 11'h7FF, 1'b1), 40);
		wait_idle();
	endtask

	task automatic test_backpressure();
		// The receiver holds off for a long stretch while words keep coming, so the
		// output register fills and the parser has to stall its input.
		steady_send = 1'b1;
		hold_req = 1'b1;
		send_command($urandom, make_header(16'h00F0, 4'hF, 11'd20, 1'b1), -1);
		steady_send = 1'b0;
		wait_idle();
	endtask

	task automatic test_random();
		int start;
		int pick;
		int count;
		logic [15:0] reg_id;
		logic [3:0] mask;
		start = useful_words;
		while (useful_words - start < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				// Well-formed command, mostly short.
				count = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 7);
				mask = ($urandom_range(0, 9) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
				reg_id = ($urandom_range(0, 7) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
					: 16'($urandom);
				send_command($urandom, make_header(reg_id, mask, 11'(count), 1'($urandom)),
					($urandom_range(0, 7) == 0) ? 1 + count + (count % 2) : -1);
			end else if (pick < 92) begin
				// Fully random header; the end of the list cuts it off at one of its first seven words, if it has that many.
				send_command($urandom, $urandom, $urandom_range(0, 6));
			end else begin
				// A stray word that ends the list on its own.
				send_word($urandom, 1'b1);
			end
		end
		wait_idle();
	endtask

	// Receiver: a stall pattern that changes from window to window, plus the long
	// hold that a test can ask for.
	initial begin
		rx_mode_t mode;
		int window;
		int tick;
		mode = RX_OPEN;
		window = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			if (window == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				window = $urandom_range(20, 120);
			end
			window--;
			tick++;
			case (mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= (tick % 3 != 0);
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [31:0] expd,
			input logic [31:0] act);
		if (expd !== act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, expd, act);
			errors++;
		end
	endfunction

	// Compares each write taken at m_* with the oldest prediction and watches for
	// a hang: too many cycles in which neither side moves a word.
	always @(posedge clk) begin
		gclp_pkg::wr_t wr;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles.", STUCK_LIMIT);
				$display("tb_gpu_command_list_parser_unit: FAIL");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_writes.size() == 0) begin
					$error("write to id 0x%0h with none expected", m_tdata[15:0]);
					errors++;
				end else begin
					wr = pending_writes.pop_front();
					check_field("reg_id", 32'(wr.reg_id), 32'(m_tdata[15:0]));
					check_field("byte_mask", 32'(wr.byte_mask), 32'(m_tdata[19:16]));
					check_field("write_data", wr.write_data, m_tdata[51:20]);
					check_field("reserved", 32'h0, 32'(m_tdata[55:52]));
					check_field("last_write", 32'(wr.last_write), 32'(m_tlast));
					writes_checked++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_writes();
		test_zero_mask();
		test_group_wrap();
		test_list_end_cut();
		test_max_count();
		test_backpressure();
		test_random();

		repeat (10) @(posedge clk);
		if (pending_writes.size() != 0) begin
			$error("%0d predicted writes never came out", pending_writes.size());
			errors++;
		end
		$display("Sent %0d list words (%0d not padding or masked off); checked %0d writes.",
			words_taken, useful_words, writes_checked);
		$display("Covered grouping wrap, zero masks, cut-off commands, the largest count %s",
			$sformatf("and %0d long hold(s).", holds_done));
		if (errors == 0)
			$display("tb_gpu_command_list_parser_unit: PASS");
		else
			$display("tb_gpu_command_list_parser_unit: FAIL");
		$finish;
	end

endmodule
